// ----- rtl/ltd_pkg.sv -----
`timescale 1ns / 1ps

package ltd_pkg;

  // width of one link or lane word
  localparam int unsigned WORD_W = 64;

  // link words and lane words carried on the channels
  localparam int unsigned NFIELDS = 3;

  typedef logic [WORD_W-1:0] word_t;

endpackage

// ----- rtl/ltd_if.sv -----
`timescale 1ns / 1ps

// request channel: one word per link and the new-event flag
interface ltd_in_if;
  logic            valid;
  logic            ready;
  logic            new_event;
  ltd_pkg::word_t  link_word_0;
  ltd_pkg::word_t  link_word_1;
  ltd_pkg::word_t  link_word_2;

  modport source (
    output valid, new_event, link_word_0, link_word_1, link_word_2,
    input  ready
  );
  modport sink (
    input  valid, new_event, link_word_0, link_word_1, link_word_2,
    output ready
  );
endinterface

// result channel: one word per lane and the data flag
interface ltd_out_if;
  logic            valid;
  logic            ready;
  logic            out_valid;
  ltd_pkg::word_t  out_word_0;
  ltd_pkg::word_t  out_word_1;
  ltd_pkg::word_t  out_word_2;

  modport source (
    output valid, out_valid, out_word_0, out_word_1, out_word_2,
    input  ready
  );
  modport sink (
    input  valid, out_valid, out_word_0, out_word_1, out_word_2,
    output ready
  );
endinterface

// ----- rtl/link_time_demux_banked.sv -----
// an accepted request is read from the banks into stage 1, then moves to the output register
// throughput: one request per cycle, ready stays high unless the result side stalls
// each bank takes one write and one read per request, so there is no interlock
// reset (rst, synchronous, active high) restores write and read sequencing
// bank contents are not cleared: no clearing pass, no start-up delay
`timescale 1ns / 1ps

module link_time_demux_banked #(
  parameter int unsigned LINKS     = 3,
  parameter int unsigned BLOCK_LEN = 48,
  parameter int unsigned PAGE_LEN  = 144
) (
  input  logic       clk,
  input  logic       rst,
  ltd_in_if.sink     links,
  ltd_out_if.source  lanes
);

  // bank geometry: two pages per bank
  localparam int unsigned MEM_LEN = 2 * PAGE_LEN;
  localparam int unsigned AW      = $clog2(MEM_LEN);
  // rotation and block index range over the links
  localparam int unsigned RW      = $clog2(LINKS);
  // write step counter tops out below BLOCK_LEN + LINKS
  localparam int unsigned SW      = $clog2(BLOCK_LEN + LINKS + 1);
  // read counter stays below BLOCK_LEN; its increment reaches BLOCK_LEN
  localparam int unsigned CW      = $clog2(BLOCK_LEN + 1);

  // ---------------------------------------------------------------------------
  // handshake: stage 1 is the bank read, then the output register
  // ---------------------------------------------------------------------------
  logic accept;
  logic out_load;
  logic s1_v;
  logic s1_act;
  logic [RW-1:0] s1_rot;
  logic o_v;

  assign out_load    = !o_v || lanes.ready;
  assign links.ready = !s1_v || out_load;
  assign accept      = links.valid && links.ready;

  // ---------------------------------------------------------------------------
  // sequencing registers
  // ---------------------------------------------------------------------------
  logic [AW-1:0] wr_off      [LINKS];
  logic [AW-1:0] wr_off_next [LINKS];
  logic [LINKS-1:0] pg_sel;
  logic [LINKS-1:0] pg_sel_next;
  logic [RW-1:0] wr_rot,   wr_rot_next;
  logic [SW-1:0] step_cnt, step_cnt_next;
  logic [RW-1:0] blk_idx,  blk_idx_next;
  logic          rd_act,   rd_act_next;
  logic [AW-1:0] rd_ptr,   rd_ptr_next;
  logic [RW-1:0] rd_rot,   rd_rot_next;
  logic [CW-1:0] rd_cnt,   rd_cnt_next;

  // state seen by this request: a new event restarts before the write
  logic [AW-1:0] cur_off [LINKS];
  logic [LINKS-1:0] cur_pg;
  logic [RW-1:0] cur_rot;
  logic [SW-1:0] cur_step;
  logic [RW-1:0] cur_blk;
  logic          cur_ract;
  logic [AW-1:0] cur_rptr;
  logic [RW-1:0] cur_rrot;
  logic [CW-1:0] cur_rcnt;

  logic          restart;
  assign restart = links.new_event;

  always_comb begin
    cur_rot  = restart ? '0 : wr_rot;
    cur_step = restart ? '0 : step_cnt;
    cur_blk  = restart ? RW'(1) : blk_idx;
    cur_ract = restart ? 1'b0 : rd_act;
    cur_rptr = restart ? AW'(PAGE_LEN) : rd_ptr;
    cur_rrot = restart ? '0 : rd_rot;
    cur_rcnt = restart ? '0 : rd_cnt;
  end

  // link words as an array, links past the third carry zero
  ltd_pkg::word_t link_word [LINKS];

  // ---------------------------------------------------------------------------
  // write side
  // ---------------------------------------------------------------------------
  logic          rot_wrap;
  logic [SW-1:0] step_inc;
  logic          blk_end;

  assign rot_wrap = (cur_rot == RW'(LINKS - 1));
  assign step_inc = cur_step + 1'b1;
  // block end is only checked when the rotation wraps
  assign blk_end  = rot_wrap && (step_inc >= SW'(BLOCK_LEN));

  always_comb begin
    wr_rot_next   = rot_wrap ? '0 : cur_rot + 1'b1;
    step_cnt_next = blk_end ? '0 : step_inc;
    if (blk_end) begin
      blk_idx_next = (cur_blk == RW'(LINKS - 1)) ? '0 : cur_blk + 1'b1;
    end else begin
      blk_idx_next = cur_blk;
    end
  end

  for (genvar i = 0; i < LINKS; i++) begin : g_link
    // restart offsets on the lower and the upper page
    localparam int unsigned BASE_LO = (i * BLOCK_LEN) % MEM_LEN;
    localparam int unsigned BASE_HI = (i * BLOCK_LEN + PAGE_LEN) % MEM_LEN;

    if (i == 0) begin : g_w0
      assign link_word[i] = links.link_word_0;
    end else if (i == 1) begin : g_w1
      assign link_word[i] = links.link_word_1;
    end else if (i == 2) begin : g_w2
      assign link_word[i] = links.link_word_2;
    end else begin : g_wz
      assign link_word[i] = '0;
    end

    always_comb begin
      if (restart) begin
        cur_pg[i]  = (i == 0);
        cur_off[i] = (i == 0) ? AW'(BASE_HI) : AW'(BASE_LO);
      end else begin
        cur_pg[i]  = pg_sel[i];
        cur_off[i] = wr_off[i];
      end
    end

    always_comb begin
      pg_sel_next[i] = cur_pg[i];
      wr_off_next[i] = cur_off[i];
      if (blk_end && (cur_blk == RW'(i))) begin
        // this link's block is done: flip page and restart its block
        pg_sel_next[i] = !cur_pg[i];
        wr_off_next[i] = cur_pg[i] ? AW'(BASE_LO) : AW'(BASE_HI);
      end else if (rot_wrap) begin
        wr_off_next[i] = (cur_off[i] == AW'(MEM_LEN - 1)) ? '0 : cur_off[i] + 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pg_sel[i] <= (i == 0);
        wr_off[i] <= (i == 0) ? AW'(BASE_HI) : AW'(BASE_LO);
      end else if (accept) begin
        pg_sel[i] <= pg_sel_next[i];
        wr_off[i] <= wr_off_next[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // read side sequencing
  // ---------------------------------------------------------------------------
  logic [CW-1:0] rcnt_inc;
  assign rcnt_inc = cur_rcnt + 1'b1;

  always_comb begin
    rd_act_next = cur_ract;
    rd_ptr_next = cur_rptr;
    rd_rot_next = cur_rrot;
    rd_cnt_next = cur_rcnt;
    if (!cur_ract) begin
      // arm once the first block of link 0 has been written
      if ((step_cnt_next == SW'(1)) && (blk_idx_next == '0)) begin
        rd_act_next = 1'b1;
        rd_ptr_next = AW'(PAGE_LEN);
        rd_rot_next = '0;
        rd_cnt_next = '0;
      end
    end else begin
      rd_ptr_next = (cur_rptr == AW'(MEM_LEN - 1)) ? '0 : cur_rptr + 1'b1;
      if (rcnt_inc >= CW'(BLOCK_LEN)) begin
        rd_cnt_next = '0;
        rd_rot_next = (cur_rrot == RW'(LINKS - 1)) ? '0 : cur_rrot + 1'b1;
      end else begin
        rd_cnt_next = rcnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_rot   <= '0;
      step_cnt <= '0;
      blk_idx  <= RW'(1);
      rd_act   <= 1'b0;
      rd_ptr   <= AW'(PAGE_LEN);
      rd_rot   <= '0;
      rd_cnt   <= '0;
    end else if (accept) begin
      wr_rot   <= wr_rot_next;
      step_cnt <= step_cnt_next;
      blk_idx  <= blk_idx_next;
      rd_act   <= rd_act_next;
      rd_ptr   <= rd_ptr_next;
      rd_rot   <= rd_rot_next;
      rd_cnt   <= rd_cnt_next;
    end
  end

  // ---------------------------------------------------------------------------
  // banks: bank b takes the word of link (b - rotation) mod LINKS
  // ---------------------------------------------------------------------------
  ltd_pkg::word_t rd_data [LINKS];

  for (genvar b = 0; b < LINKS; b++) begin : g_bank
    logic [RW:0]     lsum;
    logic [RW-1:0]   lidx;

    assign lsum = (RW+1)'(b + LINKS) - {1'b0, cur_rot};
    assign lidx = (lsum >= (RW+1)'(LINKS)) ? RW'(lsum - (RW+1)'(LINKS)) : RW'(lsum);

    ltd_bank #(
      .DEPTH (MEM_LEN),
      .AW    (AW)
    ) u_bank (
      .clk   (clk),
      .we    (accept),
      .waddr (cur_off[lidx]),
      .wdata (link_word[lidx]),
      .re    (accept),
      .raddr (cur_rptr),
      .rdata (rd_data[b])
    );
  end

  // stage 1 bookkeeping: bank data is held by the banks until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (accept) begin
      s1_v <= 1'b1;
    end else if (out_load) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act <= cur_ract;
      s1_rot <= cur_rrot;
    end
  end

  // ---------------------------------------------------------------------------
  // lane rotation and output register
  // ---------------------------------------------------------------------------
  ltd_pkg::word_t lane_word [ltd_pkg::NFIELDS];
  ltd_pkg::word_t o_word    [ltd_pkg::NFIELDS];
  logic           o_flag;

  for (genvar k = 0; k < ltd_pkg::NFIELDS; k++) begin : g_lane
    if (k < LINKS) begin : g_used
      logic [RW:0]   bsum;
      logic [RW-1:0] bidx;

      // lane k reads bank (k + rotation) mod LINKS
      assign bsum = {1'b0, s1_rot} + (RW+1)'(k);
      assign bidx = (bsum >= (RW+1)'(LINKS)) ? RW'(bsum - (RW+1)'(LINKS)) : RW'(bsum);
      assign lane_word[k] = s1_act ? rd_data[bidx] : '0;
    end else begin : g_idle
      assign lane_word[k] = '0;
    end

    always_ff @(posedge clk) begin
      if (out_load && s1_v) begin
        o_word[k] <= lane_word[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v    <= 1'b0;
      o_flag <= 1'b0;
    end else if (out_load) begin
      o_v    <= s1_v;
      o_flag <= s1_v && s1_act;
    end
  end

  assign lanes.valid      = o_v;
  assign lanes.out_valid  = o_flag;
  assign lanes.out_word_0 = o_word[0];
  assign lanes.out_word_1 = o_word[1];
  assign lanes.out_word_2 = o_word[2];

`ifndef SYNTH
  // a result waiting in stage 1 is never dropped while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_v && !out_load) |=> s1_v)
    else $error("stage 1 result lost during stall");

  // idle results carry zero words
  a_zero_idle: assert property (@(posedge clk) disable iff (rst)
    (o_v && !o_flag) |-> ((o_word[0] == '0) && (o_word[1] == '0) && (o_word[2] == '0)))
    else $error("non-zero words without data flag");

  // read pointer and read counter stay in range
  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, rd_ptr} < (AW+1)'(MEM_LEN)) && (rd_cnt < CW'(BLOCK_LEN)))
    else $error("read sequencing out of range");

  // once armed, reading only stops on a new event
  a_rd_sticky: assert property (@(posedge clk) disable iff (rst)
    (rd_act && accept && !restart) |=> rd_act)
    else $error("read side disarmed without new event");
`endif

endmodule

// ----- rtl/ltd_bank.sv -----
`timescale 1ns / 1ps

// one bank: one write port, one registered read port, write-first on a
// same-address collision
module ltd_bank #(
  parameter int unsigned DEPTH = 288,
  parameter int unsigned AW    = 9
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  ltd_pkg::word_t        wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output ltd_pkg::word_t        rdata
);

  ltd_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // the write of the same request lands before its read
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

// ----- tb/link_time_demux_banked_tb.sv -----
`timescale 1ns / 1ps

module link_time_demux_banked_tb;

  // block configuration under test
  localparam int unsigned LINKS     = 3;
  localparam int unsigned BLOCK_LEN = 48;
  localparam int unsigned PAGE_LEN  = 144;
  localparam int unsigned MEM_LEN   = 2 * PAGE_LEN;

  // run sizing
  localparam int unsigned ITEMS      = 1950;
  localparam int unsigned LATENCY    = 2;
  localparam int unsigned IDLE_LIMIT = 4000;

  // one request: new-event flag plus one word per link
  typedef struct packed {
    logic                     new_event;
    logic [ltd_pkg::NFIELDS-1:0][ltd_pkg::WORD_W-1:0] words;
  } link_req_t;

  // one result: data flag plus one word per lane
  typedef struct packed {
    logic                     out_valid;
    logic [ltd_pkg::NFIELDS-1:0][ltd_pkg::WORD_W-1:0] words;
  } lane_res_t;

  // predicts lane words from accepted requests and checks what comes out
  class demux_scoreboard;
    ltd_pkg::word_t bank_words [LINKS][MEM_LEN];
    int unsigned wr_off [LINKS];
    bit          upper_page [LINKS];
    int unsigned wr_rot;
    int unsigned step_cnt;
    int unsigned turn_link;
    bit          rd_active;
    int unsigned rd_ptr;
    int unsigned rd_rot;
    int unsigned rd_cnt;
    lane_res_t   lanes_due [$];
    int unsigned errors;

    function new();
      foreach (bank_words[b, a]) bank_words[b][a] = '0;
      errors = 0;
      restart();
    endfunction

    function int unsigned page_base(int unsigned link, bit upper);
      return (link * BLOCK_LEN + (upper ? PAGE_LEN : 0)) % MEM_LEN;
    endfunction

    // sequencing back to its event start, bank contents kept
    function void restart();
      for (int i = 0; i < LINKS; i++) begin
        upper_page[i] = (i == 0);
        wr_off[i]     = page_base(i, upper_page[i]);
      end
      wr_rot    = 0;
      step_cnt  = 0;
      turn_link = 1 % LINKS;
      rd_active = 0;
      rd_ptr    = PAGE_LEN % MEM_LEN;
      rd_rot    = 0;
      rd_cnt    = 0;
    endfunction

    // write side first, then the read side, one result per request
    function void note_request(link_req_t req);
      lane_res_t res;
      int unsigned bank;
      res = '0;
      if (req.new_event) restart();
      for (int i = 0; i < LINKS; i++) begin
        bank = (wr_rot + i) % LINKS;
        bank_words[bank][wr_off[i]] = (i < ltd_pkg::NFIELDS) ? req.words[i] : '0;
      end
      wr_rot++;
      if (step_cnt < 16'hFFFF) step_cnt++;
      if (wr_rot >= LINKS) begin
        wr_rot = 0;
        if (step_cnt >= BLOCK_LEN) begin
          // block end: the link on turn swaps pages, the rest move on
          for (int i = 0; i < LINKS; i++) begin
            if (i == turn_link) begin
              upper_page[i] = !upper_page[i];
              wr_off[i]     = page_base(i, upper_page[i]);
            end else begin
              wr_off[i] = (wr_off[i] + 1) % MEM_LEN;
            end
          end
          step_cnt  = 0;
          turn_link = (turn_link + 1) % LINKS;
        end else begin
          for (int i = 0; i < LINKS; i++) wr_off[i] = (wr_off[i] + 1) % MEM_LEN;
        end
      end
      if (!rd_active) begin
        if (step_cnt == 1 && turn_link == 0) begin
          rd_active = 1;
          rd_ptr    = PAGE_LEN % MEM_LEN;
          rd_rot    = 0;
          rd_cnt    = 0;
        end
      end else begin
        res.out_valid = 1'b1;
        for (int i = 0; i < ltd_pkg::NFIELDS; i++) begin
          if (i < LINKS) res.words[i] = bank_words[(i + rd_rot) % LINKS][rd_ptr];
        end
        rd_ptr = (rd_ptr + 1) % MEM_LEN;
        rd_cnt++;
        if (rd_cnt >= BLOCK_LEN) begin
          rd_cnt = 0;
          rd_rot = (rd_rot + 1) % LINKS;
        end
      end
      lanes_due.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    task check_lanes(lane_res_t got);
      lane_res_t want;
      if (lanes_due.size() == 0) begin
        report("lane result with no request pending");
        return;
      end
      want = lanes_due.pop_front();
      if (got.out_valid !== want.out_valid)
        report($sformatf("out_valid got %0b want %0b", got.out_valid, want.out_valid));
      for (int i = 0; i < ltd_pkg::NFIELDS; i++) begin
        if (got.words[i] !== want.words[i])
          report($sformatf("out_word_%0d got %016h want %016h", i, got.words[i],
                           want.words[i]));
      end
    endtask

    function int unsigned pending();
      return lanes_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  ltd_in_if  links_if ();
  ltd_out_if lanes_if ();

  link_time_demux_banked #(
    .LINKS     (LINKS),
    .BLOCK_LEN (BLOCK_LEN),
    .PAGE_LEN  (PAGE_LEN)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .links (links_if.sink),
    .lanes (lanes_if.source)
  );

  demux_scoreboard lane_board = new();

  // when set, neither side idles
  bit          no_gaps;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // word with the all-zero and all-one extremes showing up now and then
  function automatic ltd_pkg::word_t pick_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // hold valid low for a random gap, then present the request until it is taken
  task automatic send_request(logic ne, ltd_pkg::word_t w0, ltd_pkg::word_t w1,
                              ltd_pkg::word_t w2);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      links_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    links_if.valid       <= 1'b1;
    links_if.new_event   <= ne;
    links_if.link_word_0 <= w0;
    links_if.link_word_1 <= w1;
    links_if.link_word_2 <= w2;
    do @(posedge clk); while (!links_if.ready);
  endtask

  // let the result side empty out before the next request goes in; first wait
  // for the edge at which the last accepted request is noted
  task automatic drain_results();
    links_if.valid <= 1'b0;
    @(posedge clk);
    while (lane_board.pending() != 0) @(posedge clk);
  endtask

  // all inputs known from time zero
  initial begin
    rst                  <= 1'b1;
    links_if.valid       <= 1'b0;
    links_if.new_event   <= 1'b0;
    links_if.link_word_0 <= '0;
    links_if.link_word_1 <= '0;
    links_if.link_word_2 <= '0;
    lanes_if.ready       <= 1'b0;
    no_gaps              = 1'b0;
  end

  // result side stalls at random, with stall-free stretches when no_gaps is set
  initial begin
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        lanes_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      lanes_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // requests and results are both taken at the clock edge; the
  // prediction is made before the result check in the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (links_if.valid && links_if.ready)
        lane_board.note_request({links_if.new_event, links_if.link_word_2,
                                 links_if.link_word_1, links_if.link_word_0});
      if (lanes_if.valid && lanes_if.ready)
        lane_board.check_lanes({lanes_if.out_valid, lanes_if.out_word_2,
                                lanes_if.out_word_1, lanes_if.out_word_0});
    end
  end

  // watchdog: too many cycles in a row with no request and no result taken
  always @(posedge clk) begin
    if (rst || (links_if.valid && links_if.ready) || (lanes_if.valid && lanes_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned ev_len;
    int unsigned ev_num;
    int unsigned r;
    logic        first_ne;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: sequencing straight out of reset, extreme and
    // alternating words, walking ones, and new events early on
    send_request(1'b0, '0, '0, '0);
    send_request(1'b0, '1, '1, '1);
    send_request(1'b0, {32{2'b10}}, {32{2'b01}}, {32{2'b10}});
    send_request(1'b0, {32{2'b01}}, {32{2'b10}}, {32{2'b01}});
    send_request(1'b1, '1, '0, '1);
    send_request(1'b1, '0, '1, '0);
    sent = 6;
    for (int k = 0; k < 8; k++) begin
      send_request(1'b0, ltd_pkg::word_t'(1) << (k * 9),
                   ltd_pkg::word_t'(1) << (63 - k * 8),
                   ~(ltd_pkg::word_t'(1) << (k * 5 + 20)));
      sent++;
    end

    // random part: mostly whole events long enough to reach reading, the
    // pointer wrap and several read rotations; some short or cut-off events
    // and a few continuations that skip the new-event flag
    ev_num = 0;
    while (sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      ev_len = $urandom_range(100, 420);
      else if (r < 85) ev_len = $urandom_range(1, 96);
      else             ev_len = $urandom_range(95, 100);
      first_ne = ($urandom_range(0, 19) != 0);
      no_gaps  = ($urandom_range(0, 4) == 0);
      for (int j = 0; (j < ev_len) && (sent < ITEMS); j++) begin
        send_request((j == 0) ? first_ne : 1'b0, pick_word(), pick_word(), pick_word());
        sent++;
      end
      ev_num++;
      // sender holds off until every lane result is in, at least once
      if (ev_num == 1 || $urandom_range(0, 9) == 0) drain_results();
    end
    no_gaps = 1'b0;
    drain_results();

    repeat (LATENCY + 8) @(posedge clk);
    if (lane_board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
